// ----- rtl/core/bmp24_stream_decoder_macros.svh -----
// Assertion macros used by the checker file of the BMP decoder.
`ifndef BMP24_STREAM_DECODER_MACROS_SVH
`define BMP24_STREAM_DECODER_MACROS_SVH

// Same-cycle implication under the async reset.
`define BSD_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("bmp24 decoder: check failed");

// Next-cycle implication under the async reset.
`define BSD_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("bmp24 decoder: check failed");

`endif

// ----- rtl/core/bmp24sd_pkg.sv -----
// ----------------------------------------------------------------------------
// bmp24sd_pkg
// Types and fixed constants of the 24-bit BMP stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bmp24sd_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [2:0]  status;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [11:0] column;
		logic [11:0] row_index;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic        final_res;
	} out_item_t;

	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_SKIP   = 4'b0010,
		PH_PIXELS = 4'b0100,
		PH_DONE   = 4'b1000
	} phase_t;

	localparam logic [1:0] KIND_PIXEL  = 2'd0;
	localparam logic [1:0] KIND_FINISH = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SIGNATURE = 3'd1;
	localparam logic [2:0] ST_DIB_SIZE  = 3'd2;
	localparam logic [2:0] ST_FORMAT    = 3'd3;
	localparam logic [2:0] ST_TRUNCATED = 3'd4;
	localparam logic [2:0] ST_TOO_LARGE = 3'd5;

	localparam logic [31:0] HDR_LEN     = 32'd54;
	localparam logic [31:0] DIB_MIN     = 32'd40;
	localparam logic [32:0] FILE_HDR    = 33'd14;
	localparam logic [15:0] BPP_24      = 16'd24;
	localparam logic [15:0] SIGNATURE   = 16'h4D42;
	localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;

	// header byte positions at which a little-endian word is complete or a derived term is prepared
	localparam logic [31:0] POS_SIG      = 32'd1;
	localparam logic [31:0] POS_OFFSET   = 32'd13;
	localparam logic [31:0] POS_DIB      = 32'd17;
	localparam logic [31:0] POS_DIB_NEED = 32'd18;
	localparam logic [31:0] POS_WIDTH    = 32'd21;
	localparam logic [31:0] POS_HEIGHT   = 32'd25;
	localparam logic [31:0] POS_STRIDE   = 32'd26;
	localparam logic [31:0] POS_PRODUCT  = 32'd27;
	localparam logic [31:0] POS_NEED     = 32'd28;
	localparam logic [31:0] POS_BPP      = 32'd29;
	localparam logic [31:0] POS_COMP     = 32'd33;
	localparam logic [31:0] POS_LAST     = 32'd53;

	localparam int Q_DEPTH = 4;

endpackage

`default_nettype wire

// ----- rtl/core/bmp24sd_front.sv -----
// ----------------------------------------------------------------------------
// bmp24sd_front
// Byte parser: header capture and checks, offset skip, pixel assembly.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp24sd_front import bmp24sd_pkg::*; #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire in_item_t    item,
	input  wire logic [31:0] file_length,
	output logic [1:0]       wr_cnt,
	output out_item_t        wr0,
	output out_item_t        wr1
);

	localparam int WW = ($clog2(MAX_WIDTH + 1) < 2) ? 2 : $clog2(MAX_WIDTH + 1);
	localparam int HW = ($clog2(MAX_HEIGHT + 1) < 1) ? 1 : $clog2(MAX_HEIGHT + 1);
	localparam int SW = WW + 2;
	localparam int PW = SW + HW;
	localparam int NW = ((PW > 32) ? PW : 32) + 1;

	phase_t          phase_q, phase_d;
	logic [31:0]     pos_q, pos_d, pos_inc;
	logic [31:0]     hword_q, hword_d, hword_new;
	logic [31:0]     offset_q, offset_d;
	logic [31:0]     dib_q, dib_d;
	logic [32:0]     dib_need_q, dib_need_d;
	logic [31:0]     raw_w_q, raw_w_d;
	logic [31:0]     raw_h_q, raw_h_d;
	logic [15:0]     bitcnt_q, bitcnt_d;
	logic [31:0]     comp_q, comp_d;
	logic            sig_ok_q, sig_ok_d;
	logic [31:0]     habs_q, habs_d;
	logic [SW-1:0]   stride_q, stride_d;
	logic [PW-1:0]   prod_q, prod_d;
	logic [NW-1:0]   need_q, need_d;
	logic [WW-1:0]   width_q, width_d;
	logic [HW-1:0]   height_q, height_d;
	logic            bottom_up_q, bottom_up_d;
	logic [WW-1:0]   col_q, col_d, col_inc;
	logic [HW-1:0]   frow_q, frow_d, frow_inc;
	logic [1:0]      pad_q, pad_d;
	logic [1:0]      cph_q, cph_d;
	logic [7:0]      blue_q, blue_d;
	logic [7:0]      green_q, green_d;

	logic [2:0]      hdr_status;
	logic [31:0]     col32, row32, w32, h32;
	logic [3:0]      w3;
	out_item_t       pix_res, fin_res, rej_res;
	logic [1:0]      n;
	logic [2:0]      rej_code;
	logic [7:0]      b;
	logic            eof;

	assign b   = item.data_byte;
	assign eof = item.end_of_file;

	// header verdict, all heavy terms were prepared on earlier header bytes
	always_comb begin
		if (file_length < HDR_LEN || !sig_ok_q) begin
			hdr_status = ST_SIGNATURE;
		end else if (dib_q < DIB_MIN || {1'b0, file_length} < dib_need_q) begin
			hdr_status = ST_DIB_SIZE;
		end else if (bitcnt_q != BPP_24 || comp_q != 32'd0 || raw_w_q == 32'd0 ||
				raw_w_q[31] || raw_h_q == 32'd0) begin
			hdr_status = ST_FORMAT;
		end else if (raw_w_q > 32'(MAX_WIDTH) || habs_q > 32'(MAX_HEIGHT) ||
				offset_q < HDR_LEN) begin
			hdr_status = ST_TOO_LARGE;
		end else if (NW'(file_length) < need_q) begin
			hdr_status = ST_TRUNCATED;
		end else begin
			hdr_status = ST_OK;
		end
	end

	assign col32 = 32'(col_q);
	assign w32   = 32'(width_q);
	assign h32   = 32'(height_q);
	assign row32 = bottom_up_q ? (h32 - 32'd1 - 32'(frow_q)) : 32'(frow_q);
	assign w3    = 4'(w32[1:0]) * 4'd3;

	always_comb begin
		pix_res              = '0;
		pix_res.result_kind  = KIND_PIXEL;
		pix_res.status       = ST_OK;
		pix_res.red          = b;
		pix_res.green        = green_q;
		pix_res.blue         = blue_q;
		pix_res.alpha        = ALPHA_OPAQUE;
		pix_res.column       = col32[11:0];
		pix_res.row_index    = row32[11:0];
		pix_res.image_width  = w32[12:0];
		pix_res.image_height = h32[12:0];

		fin_res              = '0;
		fin_res.result_kind  = KIND_FINISH;
		fin_res.status       = ST_OK;
		fin_res.image_width  = w32[12:0];
		fin_res.image_height = h32[12:0];
		fin_res.final_res    = 1'b1;

		rej_res              = '0;
		rej_res.result_kind  = KIND_REJECT;
		rej_res.status       = rej_code;
		rej_res.final_res    = 1'b1;
	end

	always_comb begin
		phase_d     = phase_q;
		pos_inc     = (pos_q == 32'hFFFF_FFFF) ? pos_q : pos_q + 32'd1;
		pos_d       = pos_inc;
		hword_new   = {b, hword_q[31:8]};
		hword_d     = hword_q;
		offset_d    = offset_q;
		dib_d       = dib_q;
		dib_need_d  = dib_need_q;
		raw_w_d     = raw_w_q;
		raw_h_d     = raw_h_q;
		bitcnt_d    = bitcnt_q;
		comp_d      = comp_q;
		sig_ok_d    = sig_ok_q;
		habs_d      = habs_q;
		stride_d    = stride_q;
		prod_d      = prod_q;
		need_d      = need_q;
		width_d     = width_q;
		height_d    = height_q;
		bottom_up_d = bottom_up_q;
		col_d       = col_q;
		frow_d      = frow_q;
		pad_d       = pad_q;
		cph_d       = cph_q;
		blue_d      = blue_q;
		green_d     = green_q;
		col_inc     = col_q + WW'(1);
		frow_inc    = frow_q + HW'(1);
		n           = 2'd0;
		rej_code    = ST_SIGNATURE;
		wr0         = rej_res;
		wr1         = rej_res;

		case (phase_q)
			PH_HEADER: begin
				hword_d = hword_new;
				if (pos_q == POS_SIG) sig_ok_d = (hword_new[31:16] == SIGNATURE);
				if (pos_q == POS_OFFSET) offset_d = hword_new;
				if (pos_q == POS_DIB) dib_d = hword_new;
				if (pos_q == POS_DIB_NEED) dib_need_d = FILE_HDR + 33'(dib_q);
				if (pos_q == POS_WIDTH) raw_w_d = hword_new;
				if (pos_q == POS_HEIGHT) raw_h_d = hword_new;
				if (pos_q == POS_STRIDE) begin
					habs_d   = raw_h_q[31] ? (32'd0 - raw_h_q) : raw_h_q;
					stride_d = (SW'(raw_w_q[WW-1:0]) * SW'(3) + SW'(3)) & ~SW'(3);
				end
				if (pos_q == POS_PRODUCT) prod_d = PW'(stride_q) * PW'(habs_q[HW-1:0]);
				if (pos_q == POS_NEED) need_d = NW'(offset_q) + NW'(prod_q);
				if (pos_q == POS_BPP) bitcnt_d = hword_new[31:16];
				if (pos_q == POS_COMP) comp_d = hword_new;
				if (pos_q == POS_LAST) begin
					if (hdr_status != ST_OK) begin
						rej_code = hdr_status;
						n        = 2'd1;
						phase_d  = PH_DONE;
					end else begin
						width_d     = raw_w_q[WW-1:0];
						height_d    = habs_q[HW-1:0];
						bottom_up_d = ~raw_h_q[31];
						phase_d     = (offset_q == HDR_LEN) ? PH_PIXELS : PH_SKIP;
					end
				end else if (eof) begin
					rej_code = ST_SIGNATURE;
					n        = 2'd1;
				end
			end
			PH_SKIP: begin
				if (pos_inc >= offset_q) phase_d = PH_PIXELS;
			end
			PH_PIXELS: begin
				if (pad_q != 2'd0) begin
					pad_d = pad_q - 2'd1;
				end else if (cph_q == 2'd0) begin
					blue_d = b;
					cph_d  = 2'd1;
				end else if (cph_q == 2'd1) begin
					green_d = b;
					cph_d   = 2'd2;
				end else begin
					cph_d = 2'd0;
					wr0   = pix_res;
					n     = 2'd1;
					col_d = col_inc;
					if (col_inc >= width_q) begin
						col_d  = '0;
						frow_d = frow_inc;
						pad_d  = 2'(4'd4 - {2'b00, w3[1:0]});
						if (frow_inc >= height_q) begin
							wr1     = fin_res;
							n       = 2'd2;
							phase_d = PH_DONE;
						end
					end
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase

		if (eof) begin
			if ((phase_d == PH_SKIP || phase_d == PH_PIXELS) && n != 2'd2) begin
				rej_code = ST_TRUNCATED;
				n        = n + 2'd1;
			end
			// drop all per-file state, keep only the length register outside
			phase_d     = PH_HEADER;
			pos_d       = '0;
			hword_d     = '0;
			offset_d    = '0;
			dib_d       = '0;
			dib_need_d  = '0;
			raw_w_d     = '0;
			raw_h_d     = '0;
			bitcnt_d    = '0;
			comp_d      = '0;
			sig_ok_d    = 1'b0;
			habs_d      = '0;
			stride_d    = '0;
			prod_d      = '0;
			need_d      = '0;
			width_d     = '0;
			height_d    = '0;
			bottom_up_d = 1'b0;
			col_d       = '0;
			frow_d      = '0;
			pad_d       = '0;
			cph_d       = '0;
			blue_d      = '0;
			green_d     = '0;
		end

		wr_cnt = accept ? n : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			pos_q       <= '0;
			hword_q     <= '0;
			offset_q    <= '0;
			dib_q       <= '0;
			dib_need_q  <= '0;
			raw_w_q     <= '0;
			raw_h_q     <= '0;
			bitcnt_q    <= '0;
			comp_q      <= '0;
			sig_ok_q    <= 1'b0;
			habs_q      <= '0;
			stride_q    <= '0;
			prod_q      <= '0;
			need_q      <= '0;
			width_q     <= '0;
			height_q    <= '0;
			bottom_up_q <= 1'b0;
			col_q       <= '0;
			frow_q      <= '0;
			pad_q       <= '0;
			cph_q       <= '0;
			blue_q      <= '0;
			green_q     <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			pos_q       <= pos_d;
			hword_q     <= hword_d;
			offset_q    <= offset_d;
			dib_q       <= dib_d;
			dib_need_q  <= dib_need_d;
			raw_w_q     <= raw_w_d;
			raw_h_q     <= raw_h_d;
			bitcnt_q    <= bitcnt_d;
			comp_q      <= comp_d;
			sig_ok_q    <= sig_ok_d;
			habs_q      <= habs_d;
			stride_q    <= stride_d;
			prod_q      <= prod_d;
			need_q      <= need_d;
			width_q     <= width_d;
			height_q    <= height_d;
			bottom_up_q <= bottom_up_d;
			col_q       <= col_d;
			frow_q      <= frow_d;
			pad_q       <= pad_d;
			cph_q       <= cph_d;
			blue_q      <= blue_d;
			green_q     <= green_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/bmp24sd_rqueue.sv -----
// ----------------------------------------------------------------------------
// bmp24sd_rqueue
// Result queue: takes up to two results a cycle, hands out one a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp24sd_rqueue import bmp24sd_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic [1:0] wr_cnt,
	input  wire out_item_t wr0,
	input  wire out_item_t wr1,
	input  wire logic      rd,
	output out_item_t      head,
	output logic           empty,
	output logic           full
);

	localparam int PTRW = $clog2(Q_DEPTH);
	localparam int CNTW = $clog2(Q_DEPTH + 1);

	out_item_t         slots_q [Q_DEPTH];
	logic [PTRW-1:0]   wr_ptr_q;
	logic [PTRW-1:0]   rd_ptr_q;
	logic [CNTW-1:0]   count_q;
	logic [PTRW-1:0]   wr_ptr_nx;

	assign wr_ptr_nx = wr_ptr_q + PTRW'(1);
	assign head      = slots_q[rd_ptr_q];
	assign empty     = (count_q == '0);
	// hold off the producer unless two slots are free
	assign full      = (count_q > CNTW'(Q_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (wr_cnt != 2'd0) slots_q[wr_ptr_q] <= wr0;
		if (wr_cnt == 2'd2) slots_q[wr_ptr_nx] <= wr1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTRW'(wr_cnt);
			rd_ptr_q <= rd_ptr_q + PTRW'(rd);
			count_q  <= count_q + CNTW'(wr_cnt) - CNTW'(rd);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/bmp24_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// bmp24_stream_decoder
// Streaming decoder for uncompressed 24-bit BMP files, byte in, RGBA pixel out.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive item (one file byte, end_of_file on the last byte) and
//   push; a beat is taken when push is high and full is low.
//   Result queue: while empty is low, result holds the oldest result; pop
//   takes it. Pixels come one per B,G,R triple; the finish or rejection beat
//   carries final_res.
//   Config: cfg_wr_en/cfg_wr_data load file_length; write it between files.
//   Results: each result is registered into the queue as the byte that causes it is taken.
//   Throughput: one byte per cycle while full is low; the parser updates all state in the
//   cycle a byte is taken, and the four-entry result queue absorbs the
//   two-beat burst on the last pixel. full rises only once three results wait.
//   Header sums and the stride product are prepared on header bytes 18 to 28,
//   so the verdict on byte 53 is a set of compares.
//   Reset clears the parser to the header phase, empties the queue and zeroes
//   file_length. A stalled receiver fills the queue and then holds off push.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp24_stream_decoder import bmp24sd_pkg::*; #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire in_item_t    item,
	output logic             empty,
	input  wire logic        pop,
	output out_item_t        result,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data
);

	logic [31:0] flen_q;
	logic        accept;
	logic [1:0]  wr_cnt;
	out_item_t   wr0;
	out_item_t   wr1;

	assign accept = push & ~full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flen_q <= '0;
		end else if (cfg_wr_en) begin
			flen_q <= cfg_wr_data;
		end
	end

	bmp24sd_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.item        (item),
		.file_length (flen_q),
		.wr_cnt      (wr_cnt),
		.wr0         (wr0),
		.wr1         (wr1)
	);

	bmp24sd_rqueue u_rqueue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_cnt (wr_cnt),
		.wr0    (wr0),
		.wr1    (wr1),
		.rd     (pop & ~empty),
		.head   (result),
		.empty  (empty),
		.full   (full)
	);

endmodule

`default_nettype wire

// ----- rtl/core/bmp24sd_checker.sv -----
// ----------------------------------------------------------------------------
// bmp24sd_checker
// Port-level checks on the result queue of the BMP decoder.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bmp24_stream_decoder_macros.svh"

module bmp24sd_checker import bmp24sd_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      empty,
	input wire logic      pop,
	input wire out_item_t result
);

	`BSD_ASSERT_IMP(a_pixel_shape, clk, arst_n,
		!empty && result.result_kind == KIND_PIXEL,
		result.alpha == ALPHA_OPAQUE && result.status == ST_OK && !result.final_res)

	`BSD_ASSERT_IMP(a_final_marks_end, clk, arst_n, !empty,
		result.final_res == (result.result_kind != KIND_PIXEL))

	`BSD_ASSERT_IMP(a_reject_clean, clk, arst_n,
		!empty && result.result_kind == KIND_REJECT,
		result.status != ST_OK && result.image_width == 13'd0 &&
		result.image_height == 13'd0 && result.column == 12'd0)

	`BSD_ASSERT_NXT(a_head_holds, clk, arst_n, !empty && !pop,
		!empty && $stable(result))

endmodule

bind bmp24_stream_decoder bmp24sd_checker u_bmp24sd_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

`default_nettype wire
